// ===== rtl/dot_bracket_structure_tolerance_match_unit_macros.svh =====
// Assertion helpers for the structure match block.
// Each expects clk and rst_n in the scope where it is used.
`ifndef DOT_BRACKET_STRUCTURE_TOLERANCE_MATCH_UNIT_MACROS_SVH
`define DOT_BRACKET_STRUCTURE_TOLERANCE_MATCH_UNIT_MACROS_SVH

// Same-cycle implication.
`define DBSTM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("structure match check failed");

// Next-cycle implication.
`define DBSTM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("structure match check failed");

`endif

// ===== rtl/dbstm_pkg.sv =====
package dbstm_pkg;

  // Character codes
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam int BUDGET_W = 13;
  localparam int REM_W    = 14;

  // Lowest value the running budget may reach
  localparam logic signed [REM_W-1:0] REM_FLOOR = -14'sd3;

  // Configuration register indexes
  localparam logic [0:0] REG_BUDGET = 1'b0;
  localparam logic [0:0] REG_LOOSE  = 1'b1;

  // Flags of a word waiting for its stack tops
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic differ;
    logic mal;
    logic mism;
    logic pair_chk;
    logic ref_chk;
  } top_flags_t;

  // Flags of a word waiting for its mark, handed to scoring
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic differ;
    logic mal;
    logic mism;
    logic pair_chg;
    logic need_mark;
  } score_flags_t;

endpackage

// ===== rtl/dbstm_ram.sv =====
module dbstm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port; a colliding read sees old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/dbstm_track.sv =====
module dbstm_track #(
  parameter int MAX_LEN = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [7:0]              own_char,
  input  logic [7:0]              ref_char,
  input  logic                    lengths_differ,
  input  logic                    last_pair,
  input  logic                    loose,
  output dbstm_pkg::score_flags_t sc,
  output logic                    mark
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = $clog2(MAX_LEN + 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] own_ptr_r, own_ptr_nxt;
  logic [PW-1:0] ref_ptr_r, ref_ptr_nxt;
  logic          mal_r, mal_nxt;

  logic acc, first, in_range;
  logic own_open, own_close, ref_open, ref_close;
  logic own_ok, ref_ok, own_push, ref_push, own_pop, ref_pop;
  logic mal_now, mism;

  logic [AW-1:0] own_raddr, ref_raddr;
  logic [AW-1:0] own_top, ref_top;

  dbstm_pkg::top_flags_t   b_r, b_nxt;
  dbstm_pkg::score_flags_t c_r, c_nxt;

  // Decode of the word at the input
  always_comb begin
    acc       = in_valid && en;
    first     = (pos_r == '0);
    in_range  = (pos_r < PW'(MAX_LEN));
    own_open  = (own_char == dbstm_pkg::CH_OPEN);
    own_close = (own_char == dbstm_pkg::CH_CLOSE);
    ref_open  = (ref_char == dbstm_pkg::CH_OPEN);
    ref_close = (ref_char == dbstm_pkg::CH_CLOSE);
    own_ok    = (own_ptr_r != '0);
    ref_ok    = (ref_ptr_r != '0);
    own_push  = in_range && own_open && (own_ptr_r < PW'(MAX_LEN));
    ref_push  = in_range && ref_open && (ref_ptr_r < PW'(MAX_LEN));
    own_pop   = own_close && own_ok;
    ref_pop   = ref_close && ref_ok;
    mism      = !(loose && (ref_char == dbstm_pkg::CH_STAR)) && (own_char != ref_char);
    mal_now   = (first ? 1'b0 : mal_r) || !in_range ||
                (own_close && !own_ok) || (ref_close && !ref_ok);
    own_raddr = AW'(own_ptr_r - PW'(1));
    ref_raddr = AW'(ref_ptr_r - PW'(1));
  end

  // Position, stack pointers and sticky malformed mark
  always_comb begin
    pos_nxt     = pos_r;
    own_ptr_nxt = own_ptr_r;
    ref_ptr_nxt = ref_ptr_r;
    mal_nxt     = mal_r;
    if (acc) begin
      mal_nxt = mal_now;
      if (last_pair) begin
        pos_nxt     = '0;
        own_ptr_nxt = '0;
        ref_ptr_nxt = '0;
      end else begin
        pos_nxt     = pos_r + PW'(in_range);
        own_ptr_nxt = own_ptr_r + PW'(own_push) - PW'(own_pop);
        ref_ptr_nxt = ref_ptr_r + PW'(ref_push) - PW'(ref_pop);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      own_ptr_r <= '0;
      ref_ptr_r <= '0;
      mal_r     <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      own_ptr_r <= own_ptr_nxt;
      ref_ptr_r <= ref_ptr_nxt;
      mal_r     <= mal_nxt;
    end
  end

  // Open-bracket stacks: push at accept, top read issued at accept
  dbstm_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_own_stack (
    .clk   (clk),
    .we    (acc && own_push),
    .waddr (own_ptr_r[AW-1:0]),
    .wdata (pos_r[AW-1:0]),
    .re    (en),
    .raddr (own_raddr),
    .rdata (own_top)
  );

  dbstm_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_ref_stack (
    .clk   (clk),
    .we    (acc && ref_push),
    .waddr (ref_ptr_r[AW-1:0]),
    .wdata (pos_r[AW-1:0]),
    .re    (en),
    .raddr (ref_raddr),
    .rdata (ref_top)
  );

  // Stage holding words whose stack tops are arriving
  always_comb begin
    b_nxt.valid    = acc;
    b_nxt.first    = first;
    b_nxt.last     = last_pair;
    b_nxt.differ   = lengths_differ;
    b_nxt.mal      = mal_now;
    b_nxt.mism     = mism;
    b_nxt.pair_chk = own_close && ref_close && own_ok && ref_ok;
    b_nxt.ref_chk  = ref_close && !own_close && ref_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (en) begin
      b_r <= b_nxt;
    end
  end

  // Compare partners, then look up the own-open mark at the ref partner
  always_comb begin
    c_nxt.valid     = b_r.valid;
    c_nxt.first     = b_r.first;
    c_nxt.last      = b_r.last;
    c_nxt.differ    = b_r.differ;
    c_nxt.mal       = b_r.mal;
    c_nxt.mism      = b_r.mism;
    c_nxt.pair_chg  = b_r.pair_chk && (own_top != ref_top);
    c_nxt.need_mark = c_nxt.pair_chg || b_r.ref_chk;
  end

  // Mark per position: written at accept, read one stage later
  dbstm_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_marks (
    .clk   (clk),
    .we    (acc && in_range),
    .waddr (pos_r[AW-1:0]),
    .wdata (own_open),
    .re    (en),
    .raddr (ref_top),
    .rdata (mark)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else if (en) begin
      c_r <= c_nxt;
    end
  end

  assign sc = c_r;

endmodule

// ===== rtl/dbstm_score.sv =====
module dbstm_score (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dbstm_pkg::score_flags_t                sc,
  input  logic                                   mark,
  input  logic [dbstm_pkg::BUDGET_W-1:0]         budget,
  input  logic                                   out_ready,
  output logic                                   en,
  output logic                                   out_valid,
  output logic                                   still_match,
  output logic signed [dbstm_pkg::REM_W-1:0]     budget_left,
  output logic                                   malformed,
  output logic                                   final_verdict
);

  logic signed [dbstm_pkg::REM_W-1:0] rem_r, rem_nxt, base;
  logic signed [dbstm_pkg::REM_W:0]   diff;
  logic                               failed_r, failed_nxt;
  logic [1:0]                         cost;
  logic                               upd;

  logic                               valid_r;
  logic                               still_r, mal_r, fin_r;
  logic signed [dbstm_pkg::REM_W-1:0] left_r;

  // Pipeline moves whenever the output register is empty or being taken
  assign en  = !valid_r || out_ready;
  assign upd = en && sc.valid;

  // Charges for this word, saturating at the floor
  always_comb begin
    cost = {1'b0, sc.mism} + {1'b0, sc.pair_chg} + {1'b0, sc.need_mark && mark};
    base = sc.first ? $signed({1'b0, budget}) : rem_r;
    diff = (dbstm_pkg::REM_W + 1)'(base) - $signed({{(dbstm_pkg::REM_W - 1){1'b0}}, cost});
    if (diff < -15'sd3) begin
      rem_nxt = dbstm_pkg::REM_FLOOR;
    end else begin
      rem_nxt = diff[dbstm_pkg::REM_W-1:0];
    end
    failed_nxt = (sc.first ? 1'b0 : failed_r) || sc.differ || rem_nxt[dbstm_pkg::REM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      failed_r <= 1'b0;
    end else if (upd) begin
      rem_r    <= rem_nxt;
      failed_r <= failed_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= sc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      still_r <= !failed_nxt;
      left_r  <= rem_nxt;
      mal_r   <= sc.mal;
      fin_r   <= sc.last && !failed_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign still_match   = still_r;
  assign budget_left   = left_r;
  assign malformed     = mal_r;
  assign final_verdict = fin_r;

endmodule

// ===== rtl/dot_bracket_structure_tolerance_match_unit.sv =====
// Dot-bracket structure tolerance match.
// Input words carry one character pair: in_tdata[7:0] structure under test,
// [15:8] reference, [16] lengths differ; in_tlast marks the final pair.
// One result word per input word on out_tdata: [0] still match,
// [14:1] budget left (signed, floor -3), [15] malformed, [16] final verdict.
// Configuration: cfg_index 0 is the mismatch budget, 1 is loose mode; write
// only while no words are in flight. The budget is taken at the first pair.
// Throughput is one word per clock while out_tready is high: each stack and the
// mark store is a one-write one-read RAM, and the dependent mark lookup sits in
// its own stage. An accepted word passes the stack-top, mark and output registers
// to out_tvalid. Reset clears pointers, position and flags; stack and mark
// contents are not cleared and need no sweep, so words are taken right after
// reset. When a result waits with out_tready low, the whole pipeline holds and
// in_tready drops in that same cycle; strings restart after the word marked last.
`include "dot_bracket_structure_tolerance_match_unit_macros.svh"

module dot_bracket_structure_tolerance_match_unit #(
  parameter int MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // own_char, ref_char, lengths_differ
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // still_match, budget_left, malformed, final_verdict
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic [dbstm_pkg::BUDGET_W-1:0]     budget_r;
  logic                               loose_r;
  logic                               en;
  logic                               mark;
  dbstm_pkg::score_flags_t            sc;
  logic                               still_match, malformed, final_verdict;
  logic signed [dbstm_pkg::REM_W-1:0] budget_left;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= '0;
      loose_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dbstm_pkg::REG_BUDGET: budget_r <= cfg_data;
        dbstm_pkg::REG_LOOSE:  loose_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_tready = en;

  dbstm_track #(.MAX_LEN(MAX_LEN)) u_track (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_tvalid),
    .own_char       (in_tdata[7:0]),
    .ref_char       (in_tdata[15:8]),
    .lengths_differ (in_tdata[16]),
    .last_pair      (in_tlast),
    .loose          (loose_r),
    .sc             (sc),
    .mark           (mark)
  );

  dbstm_score u_score (
    .clk           (clk),
    .rst_n         (rst_n),
    .sc            (sc),
    .mark          (mark),
    .budget        (budget_r),
    .out_ready     (out_tready),
    .en            (en),
    .out_valid     (out_tvalid),
    .still_match   (still_match),
    .budget_left   (budget_left),
    .malformed     (malformed),
    .final_verdict (final_verdict)
  );

  assign out_tdata = {7'b0, final_verdict, malformed, budget_left, still_match};

  // Checks
  `DBSTM_ASSERT_IMP(a_ready_only_on_stall, !in_tready, out_tvalid && !out_tready)
  `DBSTM_ASSERT_IMP(a_floor, out_tvalid,
                    !out_tdata[14] || (out_tdata[14:1] >= 14'h3FFD))
  `DBSTM_ASSERT_IMP(a_negative_fails, out_tvalid && out_tdata[14], !out_tdata[0])
  `DBSTM_ASSERT_IMP(a_verdict_match, out_tvalid && out_tdata[16], out_tdata[0])
  `DBSTM_ASSERT_NXT(a_reset_idle, !rst_n, !out_tvalid)

endmodule

// ===== test/dot_bracket_structure_tolerance_match_unit_tb.sv =====
`timescale 1ns / 100ps

module dot_bracket_structure_tolerance_match_unit_tb;

  localparam int         REM_W          = dbstm_pkg::REM_W;
  localparam int         BUDGET_W       = dbstm_pkg::BUDGET_W;
  localparam logic [7:0] CH_OPEN        = dbstm_pkg::CH_OPEN;
  localparam logic [7:0] CH_CLOSE       = dbstm_pkg::CH_CLOSE;
  localparam logic [7:0] CH_STAR        = dbstm_pkg::CH_STAR;
  localparam logic [0:0] REG_BUDGET     = dbstm_pkg::REG_BUDGET;
  localparam logic [0:0] REG_LOOSE      = dbstm_pkg::REG_LOOSE;
  localparam logic signed [REM_W-1:0] REM_FLOOR = dbstm_pkg::REM_FLOOR;

  localparam int         STR_CAP        = 1024;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         SHORT_TARGET   = 2000;
  localparam int         DIRECTED_N     = 21;
  localparam logic [7:0] CH_DOT         = 8'h2E;

  // Result word, packed so that it maps straight onto out_tdata[16:0]
  typedef struct packed {
    logic                    final_verdict;
    logic                    malformed;
    logic signed [REM_W-1:0] budget_left;
    logic                    still_match;
  } verdict_t;

  typedef enum logic { ROW_PAIR, ROW_CFG } row_kind_t;

  // How lengths_differ is set along a string
  typedef enum int { DIFF_NONE, DIFF_ALL, DIFF_MIXED } differ_mode_t;

  typedef struct {
    row_kind_t         kind;
    logic [7:0]        own_ch;
    logic [7:0]        rf_ch;
    logic              differ;
    logic              last;
    logic              typed;
    verdict_t          want;
    logic [0:0]        cfg_idx;
    logic [BUDGET_W-1:0] cfg_val;
  } stim_row_t;

  typedef logic [7:0] text_t[$];

  localparam verdict_t NO_WANT = '0;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // own_char, ref_char, lengths_differ
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // still_match, budget_left, malformed, final_verdict
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [12:0] cfg_data;

  dot_bracket_structure_tolerance_match_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Directed words; the verdict is typed in only where it is obvious
  // verdict fields: final_verdict, malformed, budget_left, still_match
  stim_row_t directed_rows [DIRECTED_N] = '{
    // reset settings: zero budget, strict
    '{ROW_PAIR, CH_DOT, CH_DOT, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b0, 14'sd0, 1'b1}, 1'b0, 13'd0},
    '{ROW_PAIR, CH_DOT, 8'h78, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, -14'sd1, 1'b0}, 1'b0, 13'd0},
    '{ROW_PAIR, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, -14'sd2, 1'b0}, 1'b0, 13'd0},
    '{ROW_PAIR, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, -14'sd3, 1'b0}, 1'b0, 13'd0},
    // budget sits on its floor
    '{ROW_PAIR, 8'h61, 8'h62, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, -14'sd3, 1'b0}, 1'b0, 13'd0},
    '{ROW_CFG, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_WANT, REG_BUDGET, 13'd4096},
    '{ROW_CFG, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_WANT, REG_LOOSE, 13'd1},
    // reference star is free in loose mode
    '{ROW_PAIR, CH_OPEN, CH_STAR, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 14'sd4096, 1'b1}, 1'b0, 13'd0},
    // both close, reference stack empty
    '{ROW_PAIR, CH_CLOSE, CH_CLOSE, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 14'sd4096, 1'b1}, 1'b0, 13'd0},
    // own close on empty stack
    '{ROW_PAIR, CH_CLOSE, CH_DOT, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b1, 14'sd4095, 1'b1}, 1'b0, 13'd0},
    '{ROW_PAIR, CH_OPEN, CH_OPEN, 1'b0, 1'b0, 1'b0, NO_WANT, 1'b0, 13'd0},
    '{ROW_PAIR, CH_OPEN, CH_DOT, 1'b0, 1'b0, 1'b0, NO_WANT, 1'b0, 13'd0},
    // partners differ and own opens at the reference partner
    '{ROW_PAIR, CH_CLOSE, CH_CLOSE, 1'b0, 1'b0, 1'b0, NO_WANT, 1'b0, 13'd0},
    '{ROW_PAIR, CH_OPEN, CH_OPEN, 1'b0, 1'b0, 1'b0, NO_WANT, 1'b0, 13'd0},
    // reference alone closes onto an own open
    '{ROW_PAIR, CH_DOT, CH_CLOSE, 1'b0, 1'b0, 1'b0, NO_WANT, 1'b0, 13'd0},
    '{ROW_PAIR, CH_CLOSE, CH_STAR, 1'b0, 1'b0, 1'b0, NO_WANT, 1'b0, 13'd0},
    // own star is no wildcard
    '{ROW_PAIR, CH_STAR, CH_DOT, 1'b0, 1'b0, 1'b0, NO_WANT, 1'b0, 13'd0},
    // unequal lengths
    '{ROW_PAIR, CH_CLOSE, CH_DOT, 1'b1, 1'b1, 1'b0, NO_WANT, 1'b0, 13'd0},
    '{ROW_CFG, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, NO_WANT, REG_LOOSE, 13'd0},
    // strict mode charges a reference star
    '{ROW_PAIR, CH_DOT, CH_STAR, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b0, 14'sd4095, 1'b1}, 1'b0, 13'd0},
    '{ROW_PAIR, CH_CLOSE, CH_CLOSE, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b1, 14'sd4096, 1'b1}, 1'b0, 13'd0}
  };

  // Predictor state
  logic [9:0]          own_opens_stk [STR_CAP];
  logic [9:0]          ref_opens_stk [STR_CAP];
  logic                own_open_mark [STR_CAP];
  logic [10:0]         pos_now;
  logic [10:0]         own_depth;
  logic [10:0]         ref_depth;
  logic signed [REM_W-1:0] budget_now;
  logic                failed_now;
  logic                malformed_now;
  logic [BUDGET_W-1:0] budget_cfg;
  logic                loose_cfg;

  verdict_t expected_verdicts[$];
  int       mismatches;
  int       words_seen;
  int       quiet_cycles;
  bit       no_idle;
  logic     typed_pending;
  verdict_t typed_want;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_string();
    pos_now       = '0;
    own_depth     = '0;
    ref_depth     = '0;
    budget_now    = signed'({1'b0, budget_cfg});
    failed_now    = 1'b0;
    malformed_now = 1'b0;
  endfunction

  function automatic void spend_unit();
    if (budget_now > REM_FLOOR)
      budget_now = budget_now - 14'sd1;
  endfunction

  // Works out the verdict for one character pair and advances the state
  function automatic verdict_t score_pair(logic [7:0] own_ch, logic [7:0] rf_ch,
                                          logic differ, logic last);
    verdict_t v;
    logic     in_range;
    logic     own_ok;
    logic     ref_ok;
    logic     own_close;
    logic     ref_close;
    logic [9:0] own_top;
    logic [9:0] ref_top;
    own_close = (own_ch == CH_CLOSE);
    ref_close = (rf_ch == CH_CLOSE);
    if (pos_now == 0)
      budget_now = signed'({1'b0, budget_cfg});
    if (differ)
      failed_now = 1'b1;
    if (!(loose_cfg && rf_ch == CH_STAR) && own_ch != rf_ch)
      spend_unit();

    in_range = (pos_now < STR_CAP);
    if (in_range) begin
      own_open_mark[pos_now[9:0]] = (own_ch == CH_OPEN);
      if (own_ch == CH_OPEN && own_depth < STR_CAP) begin
        own_opens_stk[own_depth[9:0]] = pos_now[9:0];
        own_depth = own_depth + 11'd1;
      end
      if (rf_ch == CH_OPEN && ref_depth < STR_CAP) begin
        ref_opens_stk[ref_depth[9:0]] = pos_now[9:0];
        ref_depth = ref_depth + 11'd1;
      end
    end else begin
      malformed_now = 1'b1;
    end

    own_ok = (own_depth != 0);
    ref_ok = (ref_depth != 0);
    if (own_close && ref_close) begin
      if (!own_ok || !ref_ok)
        malformed_now = 1'b1;
      if (own_ok && ref_ok) begin
        own_top = own_opens_stk[own_depth[9:0] - 10'd1];
        ref_top = ref_opens_stk[ref_depth[9:0] - 10'd1];
        if (own_top != ref_top) begin
          spend_unit();
          if (own_open_mark[ref_top])
            spend_unit();
        end
      end
      if (own_ok)
        own_depth = own_depth - 11'd1;
      if (ref_ok)
        ref_depth = ref_depth - 11'd1;
    end else begin
      if (own_close) begin
        if (own_ok)
          own_depth = own_depth - 11'd1;
        else
          malformed_now = 1'b1;
      end
      if (ref_close) begin
        if (ref_ok) begin
          if (own_open_mark[ref_opens_stk[ref_depth[9:0] - 10'd1]])
            spend_unit();
          ref_depth = ref_depth - 11'd1;
        end else begin
          malformed_now = 1'b1;
        end
      end
    end

    if (budget_now < 0)
      failed_now = 1'b1;
    if (in_range)
      pos_now = pos_now + 11'd1;

    v.still_match   = !failed_now;
    v.budget_left   = budget_now;
    v.malformed     = malformed_now;
    v.final_verdict = last && !failed_now;
    if (last)
      restart_string();
    return v;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Scoreboard, predictor update and watchdog, all on the rising edge
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    verdict_t predicted;
    logic     moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got = out_tdata[16:0];
        if (expected_verdicts.size() == 0) begin
          flag_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
        end else begin
          want = expected_verdicts.pop_front();
          if (got.still_match !== want.still_match)
            flag_mismatch($sformatf("word %0d still_match got %0b want %0b",
                                    words_seen, got.still_match, want.still_match));
          if (got.budget_left !== want.budget_left)
            flag_mismatch($sformatf("word %0d budget_left got %0d want %0d", words_seen,
                                    int'(got.budget_left), int'(want.budget_left)));
          if (got.malformed !== want.malformed)
            flag_mismatch($sformatf("word %0d malformed got %0b want %0b",
                                    words_seen, got.malformed, want.malformed));
          if (got.final_verdict !== want.final_verdict)
            flag_mismatch($sformatf("word %0d final_verdict got %0b want %0b",
                                    words_seen, got.final_verdict, want.final_verdict));
        end
        words_seen++;
      end

      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        predicted = score_pair(in_tdata[7:0], in_tdata[15:8], in_tdata[16], in_tlast);
        expected_verdicts = {expected_verdicts, (typed_pending ? typed_want : predicted)};
      end

      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_BUDGET: budget_cfg = cfg_data;
          REG_LOOSE:  loose_cfg  = cfg_data[0];
          default: ;
        endcase
      end
    end

    if (moved) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("dot_bracket_structure_tolerance_match_unit_tb NOT OK");
        $finish;
      end
    end
  end

  // Result side: random stall before each word, none while no_idle is set
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic send_pair(input logic [7:0] own_ch, input logic [7:0] rf_ch,
                           input logic differ, input logic last,
                           input logic typed, input verdict_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid     <= 1'b1;
    in_tdata      <= {7'd0, differ, rf_ch, own_ch};
    in_tlast      <= last;
    typed_pending = typed;
    typed_want    = want;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [0:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 5))
      0:       return CH_OPEN;
      1:       return CH_CLOSE;
      2, 3:    return CH_DOT;
      4:       return CH_STAR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random well-formed dot-bracket text of length n
  function automatic text_t make_balanced(int n);
    text_t s;
    int    depth;
    int    left;
    depth = 0;
    for (int i = 0; i < n; i++) begin
      left = n - i;
      if (depth == left) begin
        s = {s, CH_CLOSE};
        depth--;
      end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
        s = {s, CH_CLOSE};
        depth--;
      end else if (left - depth >= 2 && $urandom_range(0, 1) == 0) begin
        s = {s, CH_OPEN};
        depth++;
      end else begin
        s = {s, CH_DOT};
      end
    end
    return s;
  endfunction

  function automatic text_t make_noise(int n);
    text_t s;
    for (int i = 0; i < n; i++)
      s = {s, pick_char()};
    return s;
  endfunction

  // Copy with the odd character swapped out
  function automatic text_t mutate(text_t src);
    text_t s;
    s = src;
    foreach (s[i])
      if ($urandom_range(0, 7) == 0)
        s[i] = pick_char();
    return s;
  endfunction

  task automatic send_string(input text_t own_s, input text_t ref_s,
                             input differ_mode_t differ_mode);
    logic differ;
    for (int i = 0; i < own_s.size(); i++) begin
      case (differ_mode)
        DIFF_NONE: differ = 1'b0;
        DIFF_ALL:  differ = 1'b1;
        default:   differ = 1'($urandom_range(0, 1));
      endcase
      // now and then hold off until the pipe is empty
      if ($urandom_range(0, 63) == 0)
        wait_drained();
      send_pair(own_s[i], ref_s[i], differ, i == own_s.size() - 1, 1'b0, NO_WANT);
    end
  endtask

  // Stimulus
  initial begin
    text_t own_s;
    text_t ref_s;
    int    n;
    int    kind;
    int    short_items;
    bit    long_done;
    logic [12:0] new_budget;

    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_BUDGET;
    cfg_data      = '0;
    no_idle       = 1'b0;
    typed_pending = 1'b0;
    typed_want    = NO_WANT;
    mismatches    = 0;
    words_seen    = 0;
    quiet_cycles  = 0;
    short_items   = 0;
    long_done     = 1'b0;
    budget_cfg    = '0;
    loose_cfg     = 1'b0;
    restart_string();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
      end else begin
        send_pair(directed_rows[i].own_ch, directed_rows[i].rf_ch, directed_rows[i].differ,
                  directed_rows[i].last, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random strings
    while (short_items < SHORT_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
        case ($urandom_range(0, 3))
          0:       new_budget = 13'd0;
          1:       new_budget = 13'd4096;
          2:       new_budget = 13'($urandom_range(0, 12));
          default: new_budget = 13'($urandom_range(0, 4096));
        endcase
        cfg_write(REG_BUDGET, new_budget);
        cfg_write(REG_LOOSE, 13'($urandom_range(0, 1)));
      end
      no_idle = ($urandom_range(0, 3) == 0);

      if (!long_done && short_items > SHORT_TARGET / 2) begin
        // one string longer than the stacks can hold
        own_s = make_balanced(STR_CAP + 6);
        ref_s = mutate(own_s);
        send_string(own_s, ref_s, DIFF_NONE);
        long_done = 1'b1;
        short_items += STR_CAP + 6;
      end else begin
        n    = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        kind = $urandom_range(0, 9);
        own_s = (kind == 9) ? make_noise(n) : make_balanced(n);
        case (kind)
          6, 7:    ref_s = make_balanced(n);
          8:       ref_s = make_noise(n);
          default: ref_s = mutate(own_s);
        endcase
        send_string(own_s, ref_s,
                    ($urandom_range(0, 9) == 0) ? differ_mode_t'($urandom_range(1, 2))
                                                : DIFF_NONE);
        short_items += n;
      end
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_verdicts.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
    if (mismatches == 0)
      $display("dot_bracket_structure_tolerance_match_unit_tb OK");
    else
      $display("dot_bracket_structure_tolerance_match_unit_tb NOT OK");
    $finish;
  end

endmodule
